// File: rtl/rfm_pkg.sv
// Shared types and constants for the remote frame to mecanum target decoder.
package rfm_pkg;

  localparam int unsigned FrameLen = 16;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned PosW     = 4;

  // Register reset values
  localparam logic [3:0]  TranslateGainRst = 4'd8;
  localparam logic [3:0]  RotateGainARst   = 4'd6;
  localparam logic [3:0]  RotateGainBRst   = 4'd8;
  localparam logic [14:0] SpinThresholdRst = 15'd3000;
  localparam logic [14:0] SpinLimitRst     = 15'd3000;

  typedef enum logic [2:0] {
    REG_TRANSLATE_GAIN = 3'd0,
    REG_ROTATE_GAIN_A  = 3'd1,
    REG_ROTATE_GAIN_B  = 3'd2,
    REG_SPIN_THRESHOLD = 3'd3,
    REG_SPIN_LIMIT     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [3:0]  translate_gain;
    logic [3:0]  rotate_gain_a;
    logic [3:0]  rotate_gain_b;
    logic [14:0] spin_threshold;
    logic [14:0] spin_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [15:0] wheel_left_front;
    logic signed [15:0] wheel_right_front;
    logic signed [15:0] wheel_right_back;
    logic signed [15:0] wheel_left_back;
    logic [1:0]         switch_left;
    logic [1:0]         switch_right;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_dz;
    logic [7:0]         button_left;
    logic [7:0]         button_right;
    logic [15:0]        key_bits;
  } out_item_t;

  // Byte 0 sits in the lowest slot
  typedef logic [FrameLen-1:0][7:0] frame_t;

endpackage

// File: rtl/rfm_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
interface rfm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rfm_frame_collect.sv
// Frame byte collector: byte position tracking, byte store and full-frame register.
module rfm_frame_collect (
  input  logic            clk_i,
  input  logic            rst_ni,
  rfm_chan_if.sink        in_i,
  output logic            frame_valid_o,
  output rfm_pkg::frame_t frame_o,
  input  logic            frame_ready_i
);
  import rfm_pkg::*;

  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic [7:0]      store_q [FrameLen-1];
  frame_t          frame_q;
  logic            frame_valid_q;

  logic            accept;
  logic            take;
  logic [PosW-1:0] pos;
  logic            last;

  assign in_i.ready = !frame_valid_q || frame_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    take = 1'b0;
    pos  = '0;
    byte_index_d = byte_index_q;
    if (in_i.data.frame_start) begin
      take = accept;
    end else if (!byte_index_q[IdxW-1]) begin
      take = accept;
      pos  = byte_index_q[PosW-1:0];
    end
    if (take) begin
      byte_index_d = {1'b0, pos} + IdxW'(1);
    end
  end

  assign last = take && (pos == PosW'(FrameLen - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= IdxW'(FrameLen);
      frame_valid_q <= 1'b0;
    end else begin
      byte_index_q <= byte_index_d;
      if (frame_ready_i) begin
        frame_valid_q <= 1'b0;
      end
      if (last) begin
        frame_valid_q <= 1'b1;
      end
    end
  end

  // Last byte goes straight into the frame register, never into the store
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FrameLen - 1; i++) begin
      if (take && pos == PosW'(i)) begin
        store_q[i] <= in_i.data.rx_byte;
      end
    end
    if (last) begin
      for (int i = 0; i < FrameLen - 1; i++) begin
        frame_q[i] <= store_q[i];
      end
      frame_q[FrameLen-1] <= in_i.data.rx_byte;
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

endmodule

// File: rtl/rfm_mixer.sv
// Channel unpack, mecanum mix, saturation, spin clamp and result register.
module rfm_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_valid_i,
  input  rfm_pkg::frame_t    frame_i,
  output logic               frame_ready_o,
  input  rfm_pkg::cfg_regs_t cfg_i,
  rfm_chan_if.source         res_o
);
  import rfm_pkg::*;

  out_item_t res_q, res_d;
  logic      res_valid_q;
  logic      load;

  logic [10:0]        raw [4];
  logic signed [10:0] ch [4];
  logic signed [16:0] p_t0, p_t1, p_a2, p_b3;
  logic signed [18:0] common, sum [4];
  logic signed [15:0] w [4];
  logic signed [16:0] thr_pos, thr_neg;
  logic               all_pos, all_neg;

  assign frame_ready_o = !res_valid_q || res_o.ready;
  assign load          = frame_valid_i && frame_ready_o;

  always_comb begin
    raw[0] = {frame_i[1][2:0], frame_i[0]};
    raw[1] = {frame_i[2][5:0], frame_i[1][7:3]};
    raw[2] = {frame_i[4][0], frame_i[3], frame_i[2][7:6]};
    raw[3] = {frame_i[5][3:0], frame_i[4][7:1]};
    // raw - 1024 on 11 bits is the raw value with its top bit flipped
    for (int i = 0; i < 4; i++) begin
      ch[i] = $signed({~raw[i][10], raw[i][9:0]});
    end

    p_t0 = 17'($signed({1'b0, cfg_i.translate_gain})) * 17'(ch[0]);
    p_t1 = 17'($signed({1'b0, cfg_i.translate_gain})) * 17'(ch[1]);
    p_a2 = 17'($signed({1'b0, cfg_i.rotate_gain_a})) * 17'(ch[2]);
    p_b3 = 17'($signed({1'b0, cfg_i.rotate_gain_b})) * 17'(ch[3]);

    common = 19'(p_a2) - 19'(p_b3);
    sum[0] = common + 19'(p_t0) + 19'(p_t1);
    sum[1] = common + 19'(p_t0) - 19'(p_t1);
    sum[2] = common - 19'(p_t0) - 19'(p_t1);
    sum[3] = common - 19'(p_t0) + 19'(p_t1);

    for (int i = 0; i < 4; i++) begin
      if (sum[i] > 19'sd32767) begin
        w[i] = 16'sh7fff;
      end else if (sum[i] < -19'sd32768) begin
        w[i] = 16'sh8000;
      end else begin
        w[i] = sum[i][15:0];
      end
    end

    thr_pos = $signed({2'b00, cfg_i.spin_threshold});
    thr_neg = -thr_pos;
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int i = 0; i < 4; i++) begin
      all_pos = all_pos && (17'(w[i]) > thr_pos);
      all_neg = all_neg && (17'(w[i]) < thr_neg);
    end
    if (all_pos) begin
      for (int i = 0; i < 4; i++) begin
        w[i] = $signed({1'b0, cfg_i.spin_limit});
      end
    end else if (all_neg) begin
      for (int i = 0; i < 4; i++) begin
        w[i] = -$signed({1'b0, cfg_i.spin_limit});
      end
    end

    res_d.wheel_left_front  = w[0];
    res_d.wheel_right_front = w[1];
    res_d.wheel_right_back  = w[2];
    res_d.wheel_left_back   = w[3];
    res_d.switch_left       = frame_i[5][7:6];
    res_d.switch_right      = frame_i[5][5:4];
    res_d.mouse_dx          = {frame_i[7], frame_i[6]};
    res_d.mouse_dy          = {frame_i[9], frame_i[8]};
    res_d.mouse_dz          = {frame_i[11], frame_i[10]};
    res_d.button_left       = frame_i[12];
    res_d.button_right      = frame_i[13];
    res_d.key_bits          = {frame_i[15], frame_i[14]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (frame_ready_o) begin
      res_valid_q <= frame_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule

// File: rtl/remote_frame_to_mecanum_targets_top.sv
// Top level: configuration registers, frame collector and wheel mixer.
//
// Usage:
//   in_i  takes one received frame byte per transfer, with frame_start set on
//         byte 0. A start always restarts the frame; bytes while no frame is
//         open, and bytes after byte 15, are dropped without a result.
//   res_o gives one result per complete frame: four saturated wheel targets
//         plus switches, mouse axes, buttons and key bits.
//   cfg_i writes gain, threshold and limit registers (index 0..4), always
//         ready; other indexes are ignored. Write only while idle.
// Path: after byte 15 is transferred the frame passes the frame register,
//   then the result register. Throughput: one byte per cycle while in_i is
//   ready; the mix is a single pass of four small gain multiplies and adds.
// Reset: no frame open, registers at their defaults, no result pending.
// Stall: when res_o is held, the finished result waits in the result
//   register and one more full frame can wait in the frame register; in_i
//   drops ready only once both are occupied.
module remote_frame_to_mecanum_targets_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfm_chan_if.sink   in_i,
  rfm_chan_if.sink   cfg_i,
  rfm_chan_if.source res_o
);
  import rfm_pkg::*;

  cfg_regs_t cfg_q;
  logic      frame_valid;
  frame_t    frame;
  logic      frame_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.translate_gain <= TranslateGainRst;
      cfg_q.rotate_gain_a  <= RotateGainARst;
      cfg_q.rotate_gain_b  <= RotateGainBRst;
      cfg_q.spin_threshold <= SpinThresholdRst;
      cfg_q.spin_limit     <= SpinLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        REG_TRANSLATE_GAIN: cfg_q.translate_gain <= cfg_i.data.value[3:0];
        REG_ROTATE_GAIN_A:  cfg_q.rotate_gain_a  <= cfg_i.data.value[3:0];
        REG_ROTATE_GAIN_B:  cfg_q.rotate_gain_b  <= cfg_i.data.value[3:0];
        REG_SPIN_THRESHOLD: cfg_q.spin_threshold <= cfg_i.data.value[14:0];
        REG_SPIN_LIMIT:     cfg_q.spin_limit     <= cfg_i.data.value[14:0];
        default: ;
      endcase
    end
  end

  rfm_frame_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame),
    .frame_ready_i (frame_ready)
  );

  rfm_mixer u_mixer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .cfg_i         (cfg_q),
    .res_o         (res_o)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking bench for the remote frame decoder and mecanum wheel mixer.
module tb_top;
  import rfm_pkg::*;

  localparam int          ChanCentre = 1024;
  localparam logic [10:0] ChanMin    = 11'h000;
  localparam logic [10:0] ChanMid    = 11'h400;
  localparam logic [10:0] ChanMax    = 11'h7ff;
  localparam logic [3:0]  GainMax    = 4'hf;
  localparam logic [14:0] LevelMax   = 15'h7fff;
  localparam int          DrainLimit = 20000;

  logic clk_i;
  logic rst_ni;

  rfm_chan_if #(.T(in_item_t))   in_if ();
  rfm_chan_if #(.T(cfg_write_t)) cfg_if ();
  rfm_chan_if #(.T(out_item_t))  res_if ();

  remote_frame_to_mecanum_targets_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // Predictor state
  frame_t      frame_bytes;
  logic [4:0]  frame_pos;
  cfg_regs_t   mix_cfg;
  out_item_t   pending_targets[$];
  int          bytes_stored;

  int          fail_count;
  int          src_idle_pct;
  int          sink_idle_pct;
  out_item_t   want_t;
  out_item_t   got_t;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic out_item_t mix_frame(input frame_t f, input cfg_regs_t g);
    int        c0, c1, c2, c3, t, a, bg, turn, thr, lim;
    int        w[4];
    logic      all_hi, all_lo;
    out_item_t r;
    c0 = int'({f[1][2:0], f[0]}) - ChanCentre;
    c1 = int'({f[2][5:0], f[1][7:3]}) - ChanCentre;
    c2 = int'({f[4][0], f[3], f[2][7:6]}) - ChanCentre;
    c3 = int'({f[5][3:0], f[4][7:1]}) - ChanCentre;
    t    = int'(g.translate_gain);
    a    = int'(g.rotate_gain_a);
    bg   = int'(g.rotate_gain_b);
    turn = a * c2 - bg * c3;
    w[0] = clip16( t * c0 + t * c1 + turn);
    w[1] = clip16( t * c0 - t * c1 + turn);
    w[2] = clip16(-t * c0 - t * c1 + turn);
    w[3] = clip16(-t * c0 + t * c1 + turn);
    thr = int'(g.spin_threshold);
    lim = int'(g.spin_limit);
    all_hi = 1'b1;
    all_lo = 1'b1;
    foreach (w[i]) begin
      all_hi &= (w[i] > thr);
      all_lo &= (w[i] < -thr);
    end
    // all_lo cannot hold when all_hi does, so the order of the two is moot
    foreach (w[i]) begin
      if (all_hi) w[i] = lim;
      else if (all_lo) w[i] = -lim;
    end
    r.wheel_left_front  = 16'(w[0]);
    r.wheel_right_front = 16'(w[1]);
    r.wheel_right_back  = 16'(w[2]);
    r.wheel_left_back   = 16'(w[3]);
    r.switch_left       = f[5][7:6];
    r.switch_right      = f[5][5:4];
    r.mouse_dx          = {f[7], f[6]};
    r.mouse_dy          = {f[9], f[8]};
    r.mouse_dz          = {f[11], f[10]};
    r.button_left       = f[12];
    r.button_right      = f[13];
    r.key_bits          = {f[15], f[14]};
    return r;
  endfunction

  function automatic void store_byte(input logic [7:0] b, input logic s);
    logic [4:0] pos;
    if (s) pos = '0;
    else if (frame_pos < 5'(FrameLen)) pos = frame_pos;
    else return;
    frame_bytes[pos[3:0]] = b;
    frame_pos = pos + 5'd1;
    bytes_stored++;
    if (pos == 5'(FrameLen - 1)) pending_targets.push_back(mix_frame(frame_bytes, mix_cfg));
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      REG_TRANSLATE_GAIN: mix_cfg.translate_gain = v[3:0];
      REG_ROTATE_GAIN_A:  mix_cfg.rotate_gain_a  = v[3:0];
      REG_ROTATE_GAIN_B:  mix_cfg.rotate_gain_b  = v[3:0];
      REG_SPIN_THRESHOLD: mix_cfg.spin_threshold = v[14:0];
      REG_SPIN_LIMIT:     mix_cfg.spin_limit     = v[14:0];
      default: ;
    endcase
  endfunction

  function automatic frame_t build_frame(input logic [10:0] c0, c1, c2, c3,
                                         input logic [1:0] sw_l, sw_r);
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    bits[43:0]  = {c3, c2, c1, c0};
    bits[45:44] = sw_r;
    bits[47:46] = sw_l;
    return frame_t'(bits);
  endfunction

  function automatic logic [10:0] pick_chan();
    case ($urandom_range(5))
      0: return ChanMin;
      1: return ChanMax;
      2: return ChanMid;
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    return build_frame(pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                       2'($urandom), 2'($urandom));
  endfunction

  function automatic logic [3:0] pick_gain();
    case ($urandom_range(3))
      0: return '0;
      1: return GainMax;
      default: return 4'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_level();
    case ($urandom_range(4))
      0: return '0;
      1: return LevelMax;
      2, 3: return 15'($urandom_range(500, 8000));
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] want, got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic check_field(input string what, input logic [15:0] want, got);
    if (want !== got) flag_mismatch(what, want, got);
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_t = res_if.data;
      if (pending_targets.size() == 0) begin
        flag_mismatch("unexpected result", '0, got_t.wheel_left_front);
      end else begin
        want_t = pending_targets.pop_front();
        check_field("wheel_left_front", want_t.wheel_left_front, got_t.wheel_left_front);
        check_field("wheel_right_front", want_t.wheel_right_front, got_t.wheel_right_front);
        check_field("wheel_right_back", want_t.wheel_right_back, got_t.wheel_right_back);
        check_field("wheel_left_back", want_t.wheel_left_back, got_t.wheel_left_back);
        check_field("switch_left", 16'(want_t.switch_left), 16'(got_t.switch_left));
        check_field("switch_right", 16'(want_t.switch_right), 16'(got_t.switch_right));
        check_field("mouse_dx", want_t.mouse_dx, got_t.mouse_dx);
        check_field("mouse_dy", want_t.mouse_dy, got_t.mouse_dy);
        check_field("mouse_dz", want_t.mouse_dz, got_t.mouse_dz);
        check_field("button_left", 16'(want_t.button_left), 16'(got_t.button_left));
        check_field("button_right", 16'(want_t.button_right), 16'(got_t.button_right));
        check_field("key_bits", want_t.key_bits, got_t.key_bits);
      end
    end
  end

  // Valid stays up after a transfer; the next call either drives a new byte
  // or drops valid for its gap cycles.
  task automatic send_byte(input logic [7:0] b, input logic s);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{rx_byte: b, frame_start: s};
    do @(posedge clk_i); while (!in_if.ready);
    store_byte(b, s);
  endtask

  task automatic send_frame(input frame_t f, input int count);
    send_byte(f[0], 1'b1);
    for (int i = 1; i < count; i++) send_byte(f[i], 1'b0);
  endtask

  // Lets the block finish everything in flight before a register write.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, v);
  endtask

  // Upper bits of each write carry junk; one write to an unused index too.
  task automatic program_regs(input logic [3:0] t, a, b, input logic [14:0] thr, lim);
    logic [15:0] junk;
    wait_idle();
    junk = 16'($urandom);
    write_reg(3'(REG_SPIN_LIMIT) + 3'($urandom_range(1, 3)), 16'($urandom));
    write_reg(REG_TRANSLATE_GAIN, {junk[15:4], t});
    write_reg(REG_ROTATE_GAIN_A, {junk[11:0], a});
    write_reg(REG_ROTATE_GAIN_B, {junk[7:0], junk[15:12], b});
    write_reg(REG_SPIN_THRESHOLD, {junk[15], thr});
    write_reg(REG_SPIN_LIMIT, {junk[0], lim});
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_frame('0, FrameLen);
    send_frame('1, FrameLen);
  endtask

  task automatic test_restart_and_overrun();
    send_frame(random_frame(), 5);
    send_frame(random_frame(), FrameLen);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_frame(random_frame(), FrameLen);
  endtask

  task automatic test_spin_clamp();
    program_regs(TranslateGainRst, RotateGainARst, RotateGainBRst,
                 SpinThresholdRst, SpinLimitRst);
    send_frame(build_frame(ChanMid, ChanMid, ChanMax, ChanMin, 2'b01, 2'b10), FrameLen);
    send_frame(build_frame(ChanMid, ChanMid, ChanMin, ChanMax, 2'b10, 2'b01), FrameLen);
  endtask

  task automatic test_sum_saturation();
    program_regs(GainMax, GainMax, GainMax, LevelMax, '0);
    send_frame(build_frame(ChanMax, ChanMax, ChanMax, ChanMin, 2'b11, 2'b00), FrameLen);
    send_frame(build_frame(ChanMin, ChanMin, ChanMin, ChanMax, 2'b00, 2'b11), FrameLen);
  endtask

  task automatic test_zero_gains();
    program_regs('0, '0, '0, '0, LevelMax);
    send_frame(random_frame(), FrameLen);
    // threshold zero with only the third channel live: any nonzero turn clamps
    program_regs('0, GainMax, '0, '0, LevelMax);
    send_frame(build_frame(ChanMid, ChanMid, ChanMax, ChanMid, 2'b01, 2'b01), FrameLen);
    send_frame(build_frame(ChanMid, ChanMid, ChanMin, ChanMid, 2'b10, 2'b10), FrameLen);
  endtask

  task automatic test_random_traffic(input int src_pct, sink_pct, input int n_bytes);
    int target;
    int pick;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int blk = 0; blk < 4; blk++) begin
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_level(), pick_level());
      target = bytes_stored + n_bytes / 4;
      while (bytes_stored < target) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          send_frame(random_frame(), FrameLen);
        end else if (pick < 82) begin
          send_frame(random_frame(), $urandom_range(1, FrameLen - 1));
        end else if (pick < 90) begin
          send_frame(random_frame(), FrameLen);
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(9) == 0);
        end
      end
    end
  endtask

  initial begin
    int waited;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    frame_bytes   = '0;
    frame_pos     = 5'(FrameLen);
    mix_cfg       = '{TranslateGainRst, RotateGainARst, RotateGainBRst,
                      SpinThresholdRst, SpinLimitRst};
    bytes_stored  = 0;
    fail_count    = 0;
    src_idle_pct  = 6;
    sink_idle_pct = 85;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_bytes();
    test_field_extremes();
    test_restart_and_overrun();
    test_spin_clamp();
    test_sum_saturation();
    test_zero_gains();
    test_random_traffic(6, 85, 440);
    test_random_traffic(85, 6, 440);
    test_random_traffic(0, 0, 440);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_targets.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_targets.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
